// ===== src/cbd_pkg.sv =====
// Shared types and constants for the chunked body deframer.
// No dependencies; imported by the parser core, the top level and the checker.
package cbd_pkg;

  typedef enum logic [2:0] {
    KIND_FRAME   = 3'd0,
    KIND_PAYLOAD = 3'd1,
    KIND_DONE    = 3'd2,
    KIND_BAD     = 3'd3,
    KIND_AFTER   = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload;
  } cbd_result_t;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  localparam logic [2:0] TRAIL_SKIP = 3'd2;
  localparam logic [2:0] ZEND_SKIP  = 3'd4;

endpackage

// ===== src/chunked_body_deframer.sv =====
// A result appears in the cycle after its byte transfers (output register); one byte
// per cycle while out_tready is high; the register refills in the cycle it drains.
// Reset (rst_n low, synchronous): parser back to size line start, output empty,
// deliver_payload set to 1. start_of_body clears only the parser.
// Top level of the chunked body deframer; depends on cbd_pkg and cbd_core.
module chunked_body_deframer #(
  parameter int SIZE_LINE_MAX = 16,
  parameter int COUNT_BITS    = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,   // deliver_payload
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // [7:0] body_byte
  input  logic [0:0] in_tuser,      // [0] start_of_body
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,     // [7:0] payload_byte
  output logic [2:0] out_tuser      // [2:0] kind
);
  import cbd_pkg::*;

  logic        deliver_r;
  logic        out_valid_r;
  cbd_result_t res_r;
  cbd_result_t res;
  logic        in_xfer;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  cbd_core #(
    .SIZE_LINE_MAX(SIZE_LINE_MAX),
    .COUNT_BITS   (COUNT_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (in_xfer),
    .body_byte    (in_tdata),
    .start_of_body(in_tuser[0]),
    .deliver      (deliver_r),
    .result       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deliver_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) deliver_r <= cfg_wr_data;
      if (in_xfer) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r.payload;
  assign out_tuser  = res_r.kind;

endmodule

// ===== src/cbd_core.sv =====
// Chunked framing parser: state registers plus the per-byte next-state logic.
// Depends on cbd_pkg.
module cbd_core #(
  parameter int SIZE_LINE_MAX = 16,
  parameter int COUNT_BITS    = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          body_byte,
  input  logic                start_of_body,
  input  logic                deliver,
  output cbd_pkg::cbd_result_t result
);
  import cbd_pkg::*;

  typedef enum logic [2:0] {
    PH_SIZE, PH_DATA, PH_TRAIL, PH_ZEND, PH_DONE, PH_BAD
  } phase_t;

  localparam logic [4:0] LINE_LAST = 5'(SIZE_LINE_MAX - 1);

  phase_t                  phase_r, phase_nxt, phase_cur;
  logic [COUNT_BITS-1:0]   chunk_r, chunk_nxt, chunk_cur, chunk_dec;
  logic [4:0]              line_r, line_nxt, line_cur;
  logic [2:0]              skip_r, skip_nxt, skip_cur, skip_dec;
  logic                    cr_r, cr_nxt, cr_cur;
  logic [4:0]              hex;
  logic                    ovf;

  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

  always_comb begin
    phase_cur = start_of_body ? PH_SIZE : phase_r;
    chunk_cur = start_of_body ? '0 : chunk_r;
    line_cur  = start_of_body ? '0 : line_r;
    skip_cur  = start_of_body ? '0 : skip_r;
    cr_cur    = start_of_body ? 1'b0 : cr_r;
    hex       = hex_digit(body_byte);
    ovf       = |chunk_cur[COUNT_BITS-1 -: 4];
    chunk_dec = chunk_cur - 1'b1;
    skip_dec  = skip_cur - 3'd1;

    phase_nxt = phase_cur;
    chunk_nxt = chunk_cur;
    line_nxt  = line_cur;
    skip_nxt  = skip_cur;
    cr_nxt    = cr_cur;
    result.kind    = KIND_FRAME;
    result.payload = '0;

    case (phase_cur)
      PH_SIZE: begin
        if (cr_cur) begin
          if (body_byte == CHAR_LF) begin
            line_nxt = '0;
            cr_nxt   = 1'b0;
            if (chunk_cur == '0) begin
              phase_nxt = PH_TRAIL;
              skip_nxt  = TRAIL_SKIP;
            end else begin
              phase_nxt = PH_DATA;
            end
          end else begin
            phase_nxt   = PH_BAD;
            result.kind = KIND_BAD;
          end
        end else if (line_cur == '0 && body_byte == CHAR_ZERO) begin
          phase_nxt = PH_ZEND;
          skip_nxt  = ZEND_SKIP;
        end else if (line_cur >= LINE_LAST) begin
          phase_nxt   = PH_BAD;
          result.kind = KIND_BAD;
        end else if (body_byte == CHAR_CR) begin
          if (line_cur == '0) begin
            phase_nxt   = PH_BAD;
            result.kind = KIND_BAD;
          end else begin
            cr_nxt   = 1'b1;
            line_nxt = line_cur + 5'd1;
          end
        end else if (!hex[4] || ovf) begin
          phase_nxt   = PH_BAD;
          result.kind = KIND_BAD;
        end else begin
          chunk_nxt = {chunk_cur[COUNT_BITS-5:0], hex[3:0]};
          line_nxt  = line_cur + 5'd1;
        end
      end
      PH_DATA: begin
        if (deliver) begin
          result.kind    = KIND_PAYLOAD;
          result.payload = body_byte;
        end
        chunk_nxt = chunk_dec;
        if (chunk_dec == '0) begin
          phase_nxt = PH_TRAIL;
          skip_nxt  = TRAIL_SKIP;
        end
      end
      PH_TRAIL: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) phase_nxt = PH_SIZE;
      end
      PH_ZEND: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          phase_nxt   = PH_DONE;
          result.kind = KIND_DONE;
        end
      end
      PH_DONE: begin
        result.kind = KIND_AFTER;
      end
      default: begin
        phase_nxt   = PH_BAD;
        result.kind = KIND_BAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIZE;
      chunk_r <= '0;
      line_r  <= '0;
      skip_r  <= '0;
      cr_r    <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      chunk_r <= chunk_nxt;
      line_r  <= line_nxt;
      skip_r  <= skip_nxt;
      cr_r    <= cr_nxt;
    end
  end

endmodule

// ===== src/cbd_checker.sv =====
// Port-level checker for chunked_body_deframer, bound to the top level.
// Depends on cbd_pkg.
module cbd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic [0:0] in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [2:0] out_tuser
);
  import cbd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("transfer in gave no result");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_PAYLOAD |-> out_tdata == 8'h00)
    else $error("payload byte set on non-payload result");

  a_empty_size: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] && in_tdata == CHAR_CR
    |=> out_tuser == KIND_BAD)
    else $error("empty size line not flagged");

  a_zero_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] && in_tdata == CHAR_ZERO
    |=> out_tuser == KIND_FRAME)
    else $error("last-chunk marker not consumed");

endmodule

bind chunked_body_deframer cbd_checker u_cbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tdata  (in_tdata),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
